>>> hw/rtl/urlesc_pkg.sv
`timescale 1ns / 1ps

package urlesc_pkg;

  // Class of an input byte, picked once in the front part
  typedef enum logic [1:0] {
    KIND_SAFE  = 2'd0,
    KIND_AMP   = 2'd1,
    KIND_QUOTE = 2'd2,
    KIND_HEX   = 2'd3
  } kind_t;

  // One classified request as it waits in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
    logic       eos;
  } cmd_t;

  // Queue head as the back part sees it
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  localparam logic [2:0] LAST_SAFE  = 3'd0;
  localparam logic [2:0] LAST_AMP   = 3'd4;
  localparam logic [2:0] LAST_QUOTE = 3'd5;
  localparam logic [2:0] LAST_HEX   = 3'd2;

  function automatic logic url_safe_char(input logic [7:0] c);
    logic ok;
    begin
      ok = 1'b0;
      if (c >= 8'h30 && c <= 8'h39) ok = 1'b1;
      if (c >= 8'h41 && c <= 8'h5A) ok = 1'b1;
      if (c >= 8'h61 && c <= 8'h7A) ok = 1'b1;
      case (c)
        8'h2D, 8'h5F, 8'h2E, 8'h2B, 8'h21, 8'h2A, 8'h28, 8'h29, 8'h2C,
        8'h25, 8'h23, 8'h40, 8'h3D, 8'h3B, 8'h3A, 8'h2F, 8'h24, 8'h3F: ok = 1'b1;
        default: ;
      endcase
      return ok;
    end
  endfunction

  function automatic kind_t classify(input logic [7:0] c);
    kind_t k;
    begin
      if (url_safe_char(c))    k = KIND_SAFE;
      else if (c == CH_AMP)    k = KIND_AMP;
      else if (c == CH_QUOTE)  k = KIND_QUOTE;
      else                     k = KIND_HEX;
      return k;
    end
  endfunction

  function automatic logic [2:0] last_index(input kind_t k);
    logic [2:0] n;
    begin
      case (k)
        KIND_SAFE:  n = LAST_SAFE;
        KIND_AMP:   n = LAST_AMP;
        KIND_QUOTE: n = LAST_QUOTE;
        KIND_HEX:   n = LAST_HEX;
        default:    n = LAST_SAFE;
      endcase
      return n;
    end
  endfunction

  // Upper-case hex digit
  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    logic [7:0] ch;
    begin
      if (d < 4'd10) ch = 8'h30 + {4'h0, d};
      else           ch = 8'h37 + {4'h0, d};
      return ch;
    end
  endfunction

  function automatic logic [7:0] amp_byte(input logic [2:0] i);
    logic [7:0] ch;
    begin
      case (i)
        3'd0:    ch = 8'h26;
        3'd1:    ch = 8'h61;
        3'd2:    ch = 8'h6D;
        3'd3:    ch = 8'h70;
        default: ch = 8'h3B;
      endcase
      return ch;
    end
  endfunction

  function automatic logic [7:0] quote_byte(input logic [2:0] i);
    logic [7:0] ch;
    begin
      case (i)
        3'd0:    ch = 8'h26;
        3'd1:    ch = 8'h23;
        3'd2:    ch = 8'h78;
        3'd3:    ch = 8'h32;
        3'd4:    ch = 8'h37;
        default: ch = 8'h3B;
      endcase
      return ch;
    end
  endfunction

  function automatic logic [7:0] seq_byte(input cmd_t c, input logic [2:0] i);
    logic [7:0] ch;
    logic [7:0] hi;
    logic [7:0] lo;
    begin
      hi = (c.raw >> 4) & NIBBLE_MASK;
      lo = c.raw & NIBBLE_MASK;
      case (c.kind)
        KIND_SAFE:  ch = c.raw;
        KIND_AMP:   ch = amp_byte(i);
        KIND_QUOTE: ch = quote_byte(i);
        KIND_HEX: begin
          case (i)
            3'd0:    ch = CH_PERCENT;
            3'd1:    ch = hex_digit(hi[3:0]);
            default: ch = hex_digit(lo[3:0]);
          endcase
        end
        default:    ch = c.raw;
      endcase
      return ch;
    end
  endfunction

endpackage

>>> hw/rtl/urlesc_if.sv
`timescale 1ns / 1ps

interface urlesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface urlesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;

  modport source (output valid, output out_byte, output run_last, output string_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_last,
                  output ready);
endinterface

>>> hw/rtl/urlesc_front.sv
`timescale 1ns / 1ps

module urlesc_front (
  input  logic                clk,
  input  logic                rst_n,
  urlesc_in_if.sink           in_ch,
  input  logic                pop,
  output urlesc_pkg::head_t   head
);
  import urlesc_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;
  cmd_t       cmd_in;

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (count_r != 2'd0);

  always_comb begin
    cmd_in.kind = classify(in_ch.in_byte);
    cmd_in.raw  = in_ch.in_byte;
    cmd_in.eos  = in_ch.end_of_string;
  end

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload slots carry no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> hw/rtl/urlesc_back.sv
`timescale 1ns / 1ps

module urlesc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  urlesc_pkg::head_t   head,
  output logic                pop,
  urlesc_out_if.source        out_ch
);
  import urlesc_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       run_last_r;
  logic       str_last_r;
  logic       load;
  logic       last;

  assign load = head.valid && (!vld_r || out_ch.ready);
  assign last = (idx_r == last_index(head.cmd.kind));
  assign pop  = load && last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last ? 3'd0 : idx_r + 3'd1;
    end
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= seq_byte(head.cmd, idx_r);
      run_last_r <= last;
      str_last_r <= last && head.cmd.eos;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.out_byte    = byte_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.string_last = str_last_r;

endmodule

>>> hw/rtl/url_href_escaper.sv
`timescale 1ns / 1ps

// Channel  Dir  Payload                              Handshake
// in_ch    in   in_byte[7:0], end_of_string          valid/ready
// out_ch   out  out_byte[7:0], run_last, string_last valid/ready
//
// A safe byte yields one output byte, so plain text flows at one request per cycle
// while out_ch is ready. An escape expands into three (%XX), five (&amp;) or six
// (&#x27;) bytes: the back part emits one byte per cycle while out_ch is ready.
// An accepted request passes the queue slot, then the output register, to out_ch.
// Reset is synchronous, active low, and empties the queue and output stage.
// The two-entry queue absorbs a stall on either side without loss.
module url_href_escaper (
  input  logic          clk,
  input  logic          rst_n,
  urlesc_in_if.sink     in_ch,
  urlesc_out_if.source  out_ch
);
  import urlesc_pkg::*;

  head_t head;
  logic  pop;

  // Front: classify each byte and hold it in the queue
  urlesc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  // Back: expand the queue head into its output bytes, one per cycle while out_ch
  // is ready; drop the head once its last byte is loaded into the output register
  urlesc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
